// File: rtl/sadc_pkg.sv
// ----------------------------------------------------------------------------
// sadc_pkg
// Shared types, constants and helpers for the sorted absolute distinct counter.
// ----------------------------------------------------------------------------
`default_nettype none

package sadc_pkg;

	localparam int SADC_MAX_ELEMENTS = 1024;
	localparam int SADC_VALUE_W      = 32;
	localparam int SADC_MAG_W        = SADC_VALUE_W + 1;
	localparam int SADC_COUNT_W      = 11;

	typedef logic [SADC_VALUE_W-1:0] sadc_value_t;
	typedef logic [SADC_MAG_W-1:0]   sadc_mag_t;
	typedef logic [SADC_COUNT_W-1:0] sadc_count_t;

	// Walk sequencer states, one-hot
	typedef enum logic [4:0] {
		S_LOAD  = 5'b00001,
		S_FETCH = 5'b00010,
		S_MAG   = 5'b00100,
		S_STEP  = 5'b01000,
		S_DONE  = 5'b10000
	} sadc_state_t;

	// 33-bit magnitude of a two's complement word; the most negative value
	// maps to 2^31
	function automatic sadc_mag_t sadc_magnitude(input sadc_value_t w);
		sadc_mag_t ext;
		ext = {w[SADC_VALUE_W-1], w};
		if (w[SADC_VALUE_W-1]) begin
			return (~ext) + sadc_mag_t'(1);
		end
		return ext;
	endfunction

endpackage

`default_nettype wire

// File: rtl/sadc_item_if.sv
// ----------------------------------------------------------------------------
// sadc_item_if
// Element channel: valid/ready handshake carrying one array element.
// ----------------------------------------------------------------------------
`default_nettype none

interface sadc_item_if;
	logic                  valid;
	logic                  ready;
	sadc_pkg::sadc_value_t value;
	logic                  is_last;

	modport source (output valid, output value, output is_last, input ready);
	modport sink   (input valid, input value, input is_last, output ready);
endinterface

`default_nettype wire

// File: rtl/sadc_result_if.sv
// ----------------------------------------------------------------------------
// sadc_result_if
// Result channel: valid/ready handshake carrying the distinct count.
// ----------------------------------------------------------------------------
`default_nettype none

interface sadc_result_if;
	logic                  valid;
	logic                  ready;
	sadc_pkg::sadc_count_t distinct_count;
	logic                  overflowed;

	modport source (output valid, output distinct_count, output overflowed, input ready);
	modport sink   (input valid, input distinct_count, input overflowed, output ready);
endinterface

`default_nettype wire

// File: rtl/sorted_abs_distinct_counter.sv
// ----------------------------------------------------------------------------
// sorted_abs_distinct_counter
// Counts the distinct absolute values of a sorted array of signed words.
// ----------------------------------------------------------------------------
// Elements arrive on the item channel one per cycle while the block is
// loading, and are written into an on-chip store of MAX_ELEMENTS words;
// elements beyond that are dropped and flag the result as overflowed. The
// item marked is_last closes the array and starts a two-pointer walk inward
// from both ends. Each walk step fetches both ends from the store
// (registered read), forms the two 33-bit magnitudes, then makes one compare
// that moves the larger side inward (both on a tie) and counts the step if
// its magnitude differs from the last one. Once the pointers cross, the
// count moves into the output register. The item channel is held off for
// the whole walk. The result then waits in its output register until the
// sink takes it, while the block clears itself and loads the next array;
// only a walk that ends while an earlier result is still waiting holds in
// the done state.
// No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_abs_distinct_counter #(
	parameter int MAX_ELEMENTS = sadc_pkg::SADC_MAX_ELEMENTS
) (
	input  wire           clk,
	input  wire           arst_n,
	sadc_item_if.sink     item,
	sadc_result_if.source result
);
	import sadc_pkg::*;

	// Address width of the store, count width able to hold MAX_ELEMENTS itself
	localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
	localparam int CW = $clog2(MAX_ELEMENTS + 1);
	localparam logic [CW-1:0] CAPACITY = CW'(MAX_ELEMENTS);

	sadc_state_t state_q;

	logic [CW-1:0] load_cnt_q;   // elements stored so far
	logic          drop_q;       // an element was dropped
	logic [CW-1:0] front_q;      // front pointer
	logic [CW-1:0] back1_q;      // back pointer plus one, so it never goes negative
	logic [CW-1:0] cnt_q;        // distinct magnitudes so far
	sadc_mag_t     prev_q;
	logic          prev_valid_q;

	sadc_value_t   rd_front_q;
	sadc_value_t   rd_back_q;
	sadc_mag_t     mag_front_q;
	sadc_mag_t     mag_back_q;

	// Output register, parts the result from the next array
	logic          out_valid_q;
	sadc_count_t   out_count_q;
	logic          out_over_q;

	sadc_value_t   mem_q [MAX_ELEMENTS];

	logic          item_take;
	logic          result_take;
	logic          load_out;
	logic          room;
	logic [CW-1:0] load_cnt_next;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_front_addr;
	logic [AW-1:0] rd_back_addr;
	logic [CW-1:0] back_idx;
	logic          walk_more;

	logic          front_gt;
	logic          front_lt;
	sadc_mag_t     step_mag;
	logic          step_new;

	logic [CW+SADC_COUNT_W-1:0] cnt_ext;

	// Handshake
	assign item.ready   = (state_q == S_LOAD);
	assign item_take    = item.valid && item.ready;
	assign result.valid = out_valid_q;
	assign result_take  = result.valid && result.ready;

	// Hand the finished count over once the output register is free
	assign load_out = (state_q == S_DONE) && (!out_valid_q || result_take);

	// Load side: store the element while there is room, drop it otherwise
	assign room          = (load_cnt_q < CAPACITY);
	assign load_cnt_next = room ? (load_cnt_q + CW'(1)) : load_cnt_q;
	assign wr_addr       = load_cnt_q[AW-1:0];

	// Walk side: the walk continues while front <= back
	assign walk_more     = (front_q < back1_q);
	assign back_idx      = back1_q - CW'(1);
	assign rd_front_addr = front_q[AW-1:0];
	assign rd_back_addr  = back_idx[AW-1:0];

	// Shared compare: larger magnitude moves inward, both on a tie
	assign front_gt = (mag_front_q > mag_back_q);
	assign front_lt = (mag_front_q < mag_back_q);
	assign step_mag = front_lt ? mag_back_q : mag_front_q;
	assign step_new = !prev_valid_q || (step_mag != prev_q);

	// Result fields, count masked to the output width
	assign cnt_ext               = (CW + SADC_COUNT_W)'(cnt_q);
	assign result.distinct_count = out_count_q;
	assign result.overflowed     = out_over_q;

	// Element store: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (item_take && room) begin
			mem_q[wr_addr] <= item.value;
		end
		if (state_q == S_FETCH) begin
			rd_front_q <= mem_q[rd_front_addr];
			rd_back_q  <= mem_q[rd_back_addr];
		end
	end

	// Magnitude stage registers
	always_ff @(posedge clk) begin
		if (state_q == S_MAG) begin
			mag_front_q <= sadc_magnitude(rd_front_q);
			mag_back_q  <= sadc_magnitude(rd_back_q);
		end
	end

	// Output register: capture the count, hold it until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_count_q <= '0;
			out_over_q  <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
				out_count_q <= cnt_ext[SADC_COUNT_W-1:0];
				out_over_q  <= drop_q;
			end else if (result_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Sequencer and walk state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_LOAD;
			load_cnt_q   <= '0;
			drop_q       <= 1'b0;
			front_q      <= '0;
			back1_q      <= '0;
			cnt_q        <= '0;
			prev_q       <= '0;
			prev_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (item_take) begin
						load_cnt_q <= load_cnt_next;
						if (!room) begin
							drop_q <= 1'b1;
						end
						if (item.is_last) begin
							// close the array and start the walk
							front_q      <= '0;
							back1_q      <= load_cnt_next;
							cnt_q        <= '0;
							prev_q       <= '0;
							prev_valid_q <= 1'b0;
							state_q      <= S_FETCH;
						end
					end
				end
				S_FETCH: begin
					state_q <= walk_more ? S_MAG : S_DONE;
				end
				S_MAG: begin
					state_q <= S_STEP;
				end
				S_STEP: begin
					if (!front_lt) begin
						front_q <= front_q + CW'(1);
					end
					if (!front_gt) begin
						back1_q <= back1_q - CW'(1);
					end
					if (step_new) begin
						cnt_q <= cnt_q + CW'(1);
					end
					prev_q       <= step_mag;
					prev_valid_q <= 1'b1;
					state_q      <= S_FETCH;
				end
				S_DONE: begin
					if (load_out) begin
						// count handed over, clear for the next array
						load_cnt_q   <= '0;
						drop_q       <= 1'b0;
						front_q      <= '0;
						back1_q      <= '0;
						cnt_q        <= '0;
						prev_q       <= '0;
						prev_valid_q <= 1'b0;
						state_q      <= S_LOAD;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	// the fill count never passes the capacity
	a_load_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		load_cnt_q <= CAPACITY)
		else $error("load count beyond capacity");

	// a compare step only runs with the pointers still apart or meeting
	a_step_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_STEP) |-> (front_q < back1_q) && (back1_q <= load_cnt_q))
		else $error("walk step outside the stored array");

	// every finished array counts at least one magnitude, never more than stored
	a_result_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) |-> (cnt_q != '0) && (cnt_q <= load_cnt_q))
		else $error("distinct count out of range");

	// a handed-over count leaves the block empty and ready for a new array
	a_clear_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> (load_cnt_q == '0) && !drop_q && item.ready)
		else $error("block not cleared after result");

	// a waiting result holds still until taken
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |=> result.valid
			&& $stable(result.distinct_count) && $stable(result.overflowed))
		else $error("result changed while waiting");
`endif

endmodule

`default_nettype wire

// File: tb/sorted_abs_distinct_counter_tb.sv
// ----------------------------------------------------------------------------
// sorted_abs_distinct_counter_tb
// Self-checking bench for the sorted absolute distinct counter.
// ----------------------------------------------------------------------------
// Arrays go in on the item channel and counts come back on the result
// channel. A short table first covers the extremes of the word: zero, the
// most negative value, the most positive value and minus one. It also covers
// mirrored pairs, runs of duplicates and an unsorted array. Random arrays
// follow. Most are sorted, and their contents are drawn so that magnitudes
// often meet from both ends. One last array runs one element past the store,
// so the store fills exactly and its closing element is dropped. Every
// accepted item feeds a behavioural walk kept in the bench. Each count that
// comes back is compared field by field with the oldest outstanding one. Both
// sides idle at random, apart from one calm stretch.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_abs_distinct_counter_tb;

	import sadc_pkg::*;

	localparam int IDLE_PERCENT   = 6;
	localparam int NOISE_PERCENT  = 15;
	localparam int ITEMS_TARGET   = 500;
	localparam int SETTLE_CYCLES  = 32;
	localparam int DIRECTED_ROWS  = 22;

	// Styles of random content
	localparam int STYLE_NEAR_ZERO = 0;
	localparam int STYLE_FULL      = 1;
	localparam int STYLE_EXTREMES  = 2;
	localparam int STYLE_MIRRORED  = 3;

	// One table row, also used to pin the count of an array closed by it
	typedef struct packed {
		sadc_value_t value;
		logic        is_last;
		logic        pinned;
		sadc_count_t count;
		logic        over;
	} row_t;

	typedef struct packed {
		sadc_count_t distinct_count;
		logic        overflowed;
	} tally_t;

	logic clk = 1'b0;
	logic arst_n;

	sadc_item_if   item_ch ();
	sadc_result_if result_ch ();

	sorted_abs_distinct_counter DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	always #5 clk = ~clk;

	// Directed arrays; a count is typed in only where it is obvious
	row_t directed_rows [DIRECTED_ROWS] = '{
		// single elements at the edges of the word
		'{32'h0000_0000, 1'b1, 1'b1, 11'd1, 1'b0},
		'{32'h8000_0000, 1'b1, 1'b1, 11'd1, 1'b0},
		'{32'h7FFF_FFFF, 1'b1, 1'b1, 11'd1, 1'b0},
		'{32'hFFFF_FFFF, 1'b1, 1'b1, 11'd1, 1'b0},
		// extremes with a mirrored pair in the middle
		'{32'h8000_0000, 1'b0, 1'b0, 11'd0, 1'b0},
		'{32'hFFFF_FFFB, 1'b0, 1'b0, 11'd0, 1'b0},
		'{32'h0000_0000, 1'b0, 1'b0, 11'd0, 1'b0},
		'{32'h0000_0005, 1'b0, 1'b0, 11'd0, 1'b0},
		'{32'h7FFF_FFFF, 1'b1, 1'b0, 11'd0, 1'b0},
		// largest magnitudes that tie
		'{32'h8000_0001, 1'b0, 1'b0, 11'd0, 1'b0},
		'{32'h7FFF_FFFF, 1'b1, 1'b0, 11'd0, 1'b0},
		// most negative against most positive: no tie
		'{32'h8000_0000, 1'b0, 1'b0, 11'd0, 1'b0},
		'{32'h7FFF_FFFF, 1'b1, 1'b0, 11'd0, 1'b0},
		// runs of duplicates across zero
		'{32'hFFFF_FFFF, 1'b0, 1'b0, 11'd0, 1'b0},
		'{32'hFFFF_FFFF, 1'b0, 1'b0, 11'd0, 1'b0},
		'{32'h0000_0000, 1'b0, 1'b0, 11'd0, 1'b0},
		'{32'h0000_0001, 1'b0, 1'b0, 11'd0, 1'b0},
		'{32'h0000_0001, 1'b1, 1'b0, 11'd0, 1'b0},
		// unsorted array
		'{32'h0000_0005, 1'b0, 1'b0, 11'd0, 1'b0},
		'{32'hFFFF_FFFD, 1'b0, 1'b0, 11'd0, 1'b0},
		'{32'h0000_0007, 1'b0, 1'b0, 11'd0, 1'b0},
		'{32'h0000_0001, 1'b1, 1'b0, 11'd0, 1'b0}
	};

	// Bench copy of the block state
	sadc_value_t held_words [SADC_MAX_ELEMENTS];
	int          held_len;
	logic        held_dropped;

	row_t   pins_due [$];     // one entry per item driven, popped on acceptance
	tally_t counts_due [$];   // counts still to come back

	logic calm;
	int   mismatches;
	int   elements_taken;
	int   arrays_closed;
	int   counts_checked;
	int   overflow_results;

	task automatic flag_mismatch(input string what);
		$display("mismatch at %0t: %s", $time, what);
		mismatches++;
	endtask

	// 33-bit magnitude: negative words are taken from 2^32
	function automatic sadc_mag_t magnitude33(input sadc_value_t w);
		sadc_mag_t wide;
		wide = {1'b0, w};
		if (w[SADC_VALUE_W-1]) begin
			return (sadc_mag_t'(1) << SADC_VALUE_W) - wide;
		end
		return wide;
	endfunction

	// Walk both ends of the held array inward, counting changes of magnitude
	function automatic sadc_count_t count_distinct_magnitudes();
		int        lo;
		int        hi;
		int        tally;
		logic      seen;
		sadc_mag_t head;
		sadc_mag_t tail;
		sadc_mag_t taken;
		sadc_mag_t prior;
		lo    = 0;
		hi    = held_len - 1;
		tally = 0;
		seen  = 1'b0;
		prior = '0;
		while (lo <= hi) begin
			head = magnitude33(held_words[lo]);
			tail = magnitude33(held_words[hi]);
			if (head > tail) begin
				taken = head;
				lo++;
			end else if (head < tail) begin
				taken = tail;
				hi--;
			end else begin
				taken = head;
				lo++;
				hi--;
			end
			if (!seen || taken != prior) begin
				tally++;
			end
			prior = taken;
			seen  = 1'b1;
		end
		return sadc_count_t'(tally);
	endfunction

	// Offer one item, idling first at random, and hold it until taken
	task automatic push_element(input sadc_value_t v, input logic last, input row_t pin);
		while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		pins_due.push_back(pin);
		item_ch.valid   <= 1'b1;
		item_ch.value   <= v;
		item_ch.is_last <= last;
		@(posedge clk);
		while (!item_ch.ready) begin
			@(posedge clk);
		end
	endtask

	function automatic int draw_word(input int style);
		int pick;
		case (style)
			STYLE_NEAR_ZERO: return int'($urandom_range(16)) - 8;
			STYLE_FULL:      return int'($urandom);
			STYLE_EXTREMES: begin
				pick = int'($urandom_range(7));
				case (pick)
					0:       return int'(32'h8000_0000);
					1:       return int'(32'h8000_0001);
					2:       return int'(32'h7FFF_FFFE);
					3:       return int'(32'h7FFF_FFFF);
					4:       return -1;
					5:       return 1;
					6:       return int'($urandom);
					default: return 0;
				endcase
			end
			default: begin
				// few magnitudes with random sign, so both ends often tie
				pick = int'($urandom_range(3)) * 1000003;
				return $urandom_range(1) ? -pick : pick;
			end
		endcase
	endfunction

	// Build one array, sort it unless it is noise, and send it whole
	task automatic send_array(input int len, input int style, input logic sorted);
		int vals [$];
		for (int i = 0; i < len; i++) begin
			vals.push_back(draw_word(style));
		end
		if (sorted) begin
			vals.sort();
		end
		for (int i = 0; i < len; i++) begin
			push_element(sadc_value_t'(vals[i]), i == len - 1, '0);
		end
	endtask

	// Follow every accepted item and queue the count its array should give
	always @(posedge clk) begin : follow_items
		row_t   pin;
		tally_t want;
		if (arst_n && item_ch.valid && item_ch.ready) begin
			pin = pins_due.pop_front();
			elements_taken++;
			if (held_len < SADC_MAX_ELEMENTS) begin
				held_words[held_len] = item_ch.value;
				held_len++;
			end else begin
				held_dropped = 1'b1;
			end
			if (item_ch.is_last) begin
				want.distinct_count = count_distinct_magnitudes();
				want.overflowed     = held_dropped;
				if (pin.pinned) begin
					want.distinct_count = pin.count;
					want.overflowed     = pin.over;
				end
				counts_due.push_back(want);
				arrays_closed++;
				held_len     = 0;
				held_dropped = 1'b0;
			end
		end
	end

	// Stall the result side at random, except in the calm stretch
	always @(posedge clk) begin
		result_ch.ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
	end

	// Compare each accepted count with the oldest one outstanding
	always @(posedge clk) begin : check_counts
		tally_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (counts_due.size() == 0) begin
				flag_mismatch($sformatf("count %0d with none outstanding",
					result_ch.distinct_count));
			end else begin
				want = counts_due.pop_front();
				counts_checked++;
				if (result_ch.overflowed) begin
					overflow_results++;
				end
				if (result_ch.distinct_count !== want.distinct_count) begin
					flag_mismatch($sformatf("distinct_count %0d, want %0d",
						result_ch.distinct_count, want.distinct_count));
				end
				if (result_ch.overflowed !== want.overflowed) begin
					flag_mismatch($sformatf("overflowed %0b, want %0b",
						result_ch.overflowed, want.overflowed));
				end
			end
		end
	end

	initial begin
		int random_items;
		int len;
		arst_n            = 1'b0;
		item_ch.valid     = 1'b0;
		item_ch.value     = '0;
		item_ch.is_last   = 1'b0;
		result_ch.ready   = 1'b0;
		calm              = 1'b0;
		held_len          = 0;
		held_dropped      = 1'b0;
		mismatches        = 0;
		elements_taken    = 0;
		arrays_closed     = 0;
		counts_checked    = 0;
		overflow_results  = 0;
		random_items      = 0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed arrays from the table
		foreach (directed_rows[i]) begin
			push_element(directed_rows[i].value, directed_rows[i].is_last, directed_rows[i]);
		end

		// Random arrays: mostly short and sorted, some longer, some noise
		while (random_items < ITEMS_TARGET) begin
			calm = (arrays_closed >= 40 && arrays_closed < 60);
			if ($urandom_range(9) == 0) begin
				len = $urandom_range(64, 13);
			end else begin
				len = $urandom_range(12, 1);
			end
			send_array(len, $urandom_range(STYLE_MIRRORED),
				$urandom_range(99) >= NOISE_PERCENT);
			random_items += len;
		end
		calm = 1'b0;

		// Fill the store exactly, and drop the closing item past it
		send_array(SADC_MAX_ELEMENTS + 1, STYLE_MIRRORED, 1'b1);
		item_ch.valid <= 1'b0;

		// Drain outstanding counts, then let the block settle
		@(posedge clk);
		while (counts_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d arrays of %0d elements in total", arrays_closed, elements_taken);
		$display("checked %0d counts, %0d of them overflowed, %0d mismatches",
			counts_checked, overflow_results, mismatches);
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// Hard limit well beyond the slowest correct run
	initial begin
		#4_000_000;
		$display("timeout at %0t", $time);
		$display("FAIL");
		$finish;
	end

endmodule

`default_nettype wire
